// ===== design/mstt_pkg.sv =====
// Shared constants, types and helpers for the multi-slot timer table.
package mstt_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_KILL = 2'd1,
    MODE_PROC = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_KILL = 2'd1,
    KIND_FIRE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] interval;
    logic        periodic;
    logic [31:0] start;
    logic [7:0]  owner;
    logic [31:0] tag;
  } slot_entry_t;

  function automatic logic [4:0] slot_id(logic [IDX_W-1:0] idx);
    return 5'(32'(idx) + 32'd1);
  endfunction

endpackage

// ===== design/mstt_slot_ram.sv =====
// Slot payload memory: one write port, one registered read port.
module mstt_slot_ram (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [mstt_pkg::IDX_W-1:0] rd_addr_i,
  output mstt_pkg::slot_entry_t      rd_data_o,
  input  logic                       wr_en_i,
  input  logic [mstt_pkg::IDX_W-1:0] wr_addr_i,
  input  mstt_pkg::slot_entry_t      wr_data_i
);
  import mstt_pkg::*;

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/multi_slot_timer_table.sv =====
// Top level of the multi-slot timer table: control, valid bits and output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | mode, now_ms, interval_ms, periodic,
//           |           |                          | owner_id, user_tag, kill_id
//   out     | output    | out_valid_o / out_stall_i| kind, timer_id, fired_tag, status, last
//
// Kill acts on the named slot alone; set walks over the valid bits to the first free slot;
// process steps the slot memory read port one slot per cycle while no output stall holds the walk.
// Output stalls hold the walk whenever a result cannot move into the output register.
// Reset clears all valid bits at once; slot payload memory is not cleared.
// One item is in work at a time; in_stall_o is high while an item is in work.
module multi_slot_timer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] interval_ms_i,
  input  logic        periodic_i,
  input  logic [7:0]  owner_id_i,
  input  logic [31:0] user_tag_i,
  input  logic [15:0] kill_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  timer_id_o,
  output logic [31:0] fired_tag_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import mstt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_KILL,
    ST_PROC
  } state_e;

  state_e             state_q;
  logic [SLOTS-1:0]   valid_q;
  logic [CNT_W-1:0]   scan_q;
  logic               ev_vld_q;
  logic [IDX_W-1:0]   ev_idx_q;
  logic               pend_vld_q;
  logic [4:0]         pend_id_q;
  logic [31:0]        pend_tag_q;

  logic [31:0]        item_now_q;
  logic [31:0]        item_interval_q;
  logic               item_periodic_q;
  logic [7:0]         item_owner_q;
  logic [31:0]        item_tag_q;
  logic [15:0]        item_kid_q;

  logic               out_vld_q;
  kind_e              out_kind_q;
  logic [4:0]         out_id_q;
  logic [31:0]        out_tag_q;
  status_e            out_status_q;
  logic               out_last_q;

  slot_entry_t        rd_data;
  slot_entry_t        wr_data;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   scan_idx;
  logic               scan_more;
  logic               out_free;
  logic               out_load;
  logic [31:0]        elapsed;
  logic               ev_due;
  logic               proc_adv;
  logic               set_write;
  logic               proc_write;
  logic [15:0]        kid_m1;
  logic [IDX_W-1:0]   kid_idx;
  logic               kid_ok;

  assign scan_idx  = scan_q[IDX_W-1:0];
  assign scan_more = (scan_q != CNT_W'(SLOTS));
  assign out_free  = !out_vld_q || !out_stall_i;
  assign elapsed   = item_now_q - rd_data.start;
  assign ev_due    = ev_vld_q && valid_q[ev_idx_q] && (rd_data.owner == item_owner_q) &&
                     (elapsed >= rd_data.interval);
  assign proc_adv  = (state_q == ST_PROC) && !(ev_due && pend_vld_q && !out_free);

  assign out_load = out_free &&
                    (((state_q == ST_SET) && (!scan_more || !valid_q[scan_idx])) ||
                     (state_q == ST_KILL) ||
                     (proc_adv && ev_due && pend_vld_q) ||
                     ((state_q == ST_PROC) && !scan_more && !ev_vld_q && pend_vld_q));

  assign kid_m1  = item_kid_q - 16'd1;
  assign kid_idx = kid_m1[IDX_W-1:0];
  assign kid_ok  = (item_kid_q != 16'd0) && (item_kid_q <= 16'(SLOTS)) && valid_q[kid_idx];

  assign rd_en      = proc_adv && scan_more;
  assign set_write  = (state_q == ST_SET) && scan_more && !valid_q[scan_idx] && out_free;
  assign proc_write = proc_adv && ev_due && rd_data.periodic;
  assign wr_en      = set_write || proc_write;

  always_comb begin
    if (set_write) begin
      wr_addr          = scan_idx;
      wr_data.interval = item_interval_q;
      wr_data.periodic = item_periodic_q;
      wr_data.start    = item_now_q;
      wr_data.owner    = item_owner_q;
      wr_data.tag      = item_tag_q;
    end else begin
      wr_addr          = ev_idx_q;
      wr_data          = rd_data;
      wr_data.start    = rd_data.start + rd_data.interval;
    end
  end

  mstt_slot_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      valid_q         <= '0;
      scan_q          <= '0;
      ev_vld_q        <= 1'b0;
      ev_idx_q        <= '0;
      pend_vld_q      <= 1'b0;
      pend_id_q       <= '0;
      pend_tag_q      <= '0;
      item_now_q      <= '0;
      item_interval_q <= '0;
      item_periodic_q <= 1'b0;
      item_owner_q    <= '0;
      item_tag_q      <= '0;
      item_kid_q      <= '0;
      out_vld_q       <= 1'b0;
      out_kind_q      <= KIND_SET;
      out_id_q        <= '0;
      out_tag_q       <= '0;
      out_status_q    <= STATUS_OK;
      out_last_q      <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_now_q      <= now_ms_i;
            item_interval_q <= interval_ms_i;
            item_periodic_q <= periodic_i;
            item_owner_q    <= owner_id_i;
            item_tag_q      <= user_tag_i;
            item_kid_q      <= kill_id_i;
            scan_q          <= '0;
            ev_vld_q        <= 1'b0;
            pend_vld_q      <= 1'b0;
            unique case (mode_i)
              MODE_SET:  state_q <= ST_SET;
              MODE_KILL: state_q <= ST_KILL;
              MODE_PROC: state_q <= ST_PROC;
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SET: begin
          if (!scan_more) begin
            if (out_free) begin
              out_kind_q   <= KIND_SET;
              out_id_q     <= '0;
              out_tag_q    <= '0;
              out_status_q <= STATUS_FULL;
              out_last_q   <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end else if (!valid_q[scan_idx]) begin
            if (out_free) begin
              valid_q[scan_idx] <= 1'b1;
              out_kind_q   <= KIND_SET;
              out_id_q     <= slot_id(scan_idx);
              out_tag_q    <= '0;
              out_status_q <= STATUS_OK;
              out_last_q   <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end else begin
            scan_q <= scan_q + CNT_W'(1);
          end
        end
        ST_KILL: begin
          if (out_free) begin
            out_kind_q <= KIND_KILL;
            out_tag_q  <= '0;
            out_last_q <= 1'b0;
            if (kid_ok) begin
              valid_q[kid_idx] <= 1'b0;
              out_id_q     <= item_kid_q[4:0];
              out_status_q <= STATUS_OK;
            end else begin
              out_id_q     <= '0;
              out_status_q <= STATUS_INVALID;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_PROC: begin
          if (proc_adv) begin
            if (ev_due) begin
              if (pend_vld_q) begin
                out_kind_q   <= KIND_FIRE;
                out_id_q     <= pend_id_q;
                out_tag_q    <= pend_tag_q;
                out_status_q <= STATUS_OK;
                out_last_q   <= 1'b0;
              end
              pend_vld_q <= 1'b1;
              pend_id_q  <= slot_id(ev_idx_q);
              pend_tag_q <= rd_data.tag;
              if (!rd_data.periodic) begin
                valid_q[ev_idx_q] <= 1'b0;
              end
            end
            if (scan_more) begin
              ev_vld_q <= 1'b1;
              ev_idx_q <= scan_idx;
              scan_q   <= scan_q + CNT_W'(1);
            end else begin
              ev_vld_q <= 1'b0;
            end
            if (!scan_more && !ev_vld_q) begin
              if (!pend_vld_q) begin
                state_q <= ST_IDLE;
              end else if (out_free) begin
                out_kind_q   <= KIND_FIRE;
                out_id_q     <= pend_id_q;
                out_tag_q    <= pend_tag_q;
                out_status_q <= STATUS_OK;
                out_last_q   <= 1'b1;
                pend_vld_q   <= 1'b0;
                state_q      <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign timer_id_o  = out_id_q;
  assign fired_tag_o = out_tag_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  a_last_only_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == KIND_FIRE)
    else $error("last flag on a non-fire result");

  a_fire_status_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FIRE |-> status_o == STATUS_OK)
    else $error("fire result with nonzero status");

  a_pend_in_proc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q || ev_vld_q |-> state_q == ST_PROC)
    else $error("process pipeline busy outside process walk");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_id_q) && $stable(out_tag_q))
    else $error("stalled result overwritten");

endmodule

// ===== bench/tb_multi_slot_timer_table.sv =====
// Self-checking testbench for the multi-slot timer table: directed and random timer items.
module tb_multi_slot_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  import mstt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 4 * SLOTS;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] now;
    logic [31:0] interval;
    logic        periodic;
    logic [7:0]  owner;
    logic [31:0] tag;
    logic [15:0] kill_id;
  } timer_cmd_t;

  typedef struct {
    kind_e       kind;
    logic [4:0]  id;
    logic [31:0] tag;
    status_e     status;
    logic        last;
  } timer_reply_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = 2'd0;
  logic [31:0] now_ms_i = 32'd0;
  logic [31:0] interval_ms_i = 32'd0;
  logic        periodic_i = 1'b0;
  logic [7:0]  owner_id_i = 8'd0;
  logic [31:0] user_tag_i = 32'd0;
  logic [15:0] kill_id_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [4:0]  timer_id_o;
  logic [31:0] fired_tag_o;
  logic [1:0]  status_o;
  logic        last_o;

  multi_slot_timer_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .now_ms_i      (now_ms_i),
    .interval_ms_i (interval_ms_i),
    .periodic_i    (periodic_i),
    .owner_id_i    (owner_id_i),
    .user_tag_i    (user_tag_i),
    .kill_id_i     (kill_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .timer_id_o    (timer_id_o),
    .fired_tag_o   (fired_tag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  logic        tmr_valid    [SLOTS];
  logic [31:0] tmr_interval [SLOTS];
  logic        tmr_periodic [SLOTS];
  logic [31:0] tmr_start    [SLOTS];
  logic [7:0]  tmr_owner    [SLOTS];
  logic [31:0] tmr_tag      [SLOTS];

  timer_reply_t pending_replies[$];

  bit          no_idle = 1'b0;
  logic [31:0] clock_ms = 32'hFFFF_FF00;
  int          error_count = 0;
  int          items_sent = 0;
  int          set_count = 0;
  int          full_count = 0;
  int          kill_count = 0;
  int          invalid_count = 0;
  int          fire_count = 0;
  int          proc_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d replies outstanding", pending_replies.size());
    $display("** multi_slot_timer_table: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_timer_cmd(timer_cmd_t c);
    timer_reply_t r;
    timer_reply_t fires[$];
    logic [31:0]  elapsed;
    int           free_slot;
    r = '{kind: KIND_SET, id: 5'd0, tag: 32'd0, status: STATUS_OK, last: 1'b0};
    case (c.mode)
      MODE_SET: begin
        set_count++;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tmr_valid[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = STATUS_FULL;
          full_count++;
        end else begin
          tmr_valid[free_slot]    = 1'b1;
          tmr_interval[free_slot] = c.interval;
          tmr_periodic[free_slot] = c.periodic;
          tmr_start[free_slot]    = c.now;
          tmr_owner[free_slot]    = c.owner;
          tmr_tag[free_slot]      = c.tag;
          r.id = 5'(free_slot + 1);
        end
        pending_replies.push_back(r);
      end
      MODE_KILL: begin
        kill_count++;
        r.kind = KIND_KILL;
        if (c.kill_id >= 1 && c.kill_id <= SLOTS && tmr_valid[c.kill_id - 1]) begin
          tmr_valid[c.kill_id - 1] = 1'b0;
          r.id = 5'(c.kill_id);
        end else begin
          r.status = STATUS_INVALID;
          invalid_count++;
        end
        pending_replies.push_back(r);
      end
      MODE_PROC: begin
        proc_count++;
        r.kind = KIND_FIRE;
        for (int i = 0; i < SLOTS; i++) begin
          if (tmr_valid[i] && tmr_owner[i] == c.owner) begin
            elapsed = c.now - tmr_start[i];
            if (elapsed >= tmr_interval[i]) begin
              r.id  = 5'(i + 1);
              r.tag = tmr_tag[i];
              fires.push_back(r);
              if (tmr_periodic[i]) tmr_start[i] = tmr_start[i] + tmr_interval[i];
              else tmr_valid[i] = 1'b0;
            end
          end
        end
        if (fires.size() > 0) fires[fires.size() - 1].last = 1'b1;
        fire_count += fires.size();
        foreach (fires[k]) pending_replies.push_back(fires[k]);
      end
      default: ;
    endcase
  endfunction

  task automatic issue_cmd(input logic [1:0] mode, input logic [31:0] now,
                           input logic [31:0] interval, input logic per,
                           input logic [7:0] owner, input logic [31:0] tag,
                           input logic [15:0] kid);
    timer_cmd_t c;
    c = '{mode, now, interval, per, owner, tag, kid};
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    mode_i        <= mode;
    now_ms_i      <= now;
    interval_ms_i <= interval;
    periodic_i    <= per;
    owner_id_i    <= owner;
    user_tag_i    <= tag;
    kill_id_i     <= kid;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_timer_cmd(c);
    items_sent++;
  endtask

  task automatic issue_random_cmd();
    int          pick;
    logic [1:0]  mode;
    logic [31:0] now;
    logic [31:0] interval;
    logic [7:0]  owner;
    logic [15:0] kid;
    pick = $urandom_range(99);
    if (pick < 40) mode = MODE_SET;
    else if (pick < 60) mode = MODE_KILL;
    else if (pick < 97) mode = MODE_PROC;
    else mode = MODE_UNUSED;
    clock_ms = clock_ms + $urandom_range(0, 30);
    now = ($urandom_range(99) < 5) ? $urandom() : clock_ms;
    interval = ($urandom_range(99) < 80) ? 32'($urandom_range(0, 60)) : $urandom();
    owner = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(255));
    kid = ($urandom_range(99) < 75) ? 16'($urandom_range(0, SLOTS + 1))
                                    : 16'($urandom_range(65535));
    issue_cmd(mode, now, interval, 1'($urandom_range(1)), owner, $urandom(), kid);
  endtask

  task automatic test_empty_table();
    issue_cmd(MODE_PROC, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'd0);
    issue_cmd(MODE_KILL, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'd0);
    issue_cmd(MODE_KILL, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'(SLOTS + 1));
    issue_cmd(MODE_KILL, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'hFFFF);
    issue_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_fill_table();
    logic [31:0] interval;
    logic [31:0] tag;
    for (int i = 0; i < SLOTS; i++) begin
      interval = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : 32'(i * 10);
      tag = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
      issue_cmd(MODE_SET, 32'hFFFF_FFF0, interval, 1'(i), (i < SLOTS / 2) ? 8'h00 : 8'hFF,
                tag, 16'd0);
    end
    issue_cmd(MODE_SET, 32'h0000_0001, 32'd5, 1'b0, 8'h01, 32'h1234_5678, 16'd0);
  endtask

  task automatic test_due_walk();
    issue_cmd(MODE_PROC, 32'h0000_0100, 32'd0, 1'b0, 8'h00, 32'd0, 16'd0);
    issue_cmd(MODE_PROC, 32'hFFFF_FFF0, 32'd0, 1'b0, 8'hFF, 32'd0, 16'd0);
    issue_cmd(MODE_KILL, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'(SLOTS));
    issue_cmd(MODE_KILL, 32'd0, 32'd0, 1'b0, 8'h00, 32'd0, 16'(SLOTS));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) issue_random_cmd();
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) issue_random_cmd();
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin : reply_check
    timer_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0d tag %h status %0d last %0b",
                                  kind_o, timer_id_o, fired_tag_o, status_o, last_o));
      end else begin
        want = pending_replies.pop_front();
        if (kind_o !== want.kind || timer_id_o !== want.id || fired_tag_o !== want.tag ||
            status_o !== want.status || last_o !== want.last) begin
          report_mismatch($sformatf(
              "got kind %0d id %0d tag %h status %0d last %0b, want %0d %0d %h %0d %0b",
              kind_o, timer_id_o, fired_tag_o, status_o, last_o,
              want.kind, want.id, want.tag, want.status, want.last));
        end
      end
    end
  end

  initial begin
    int waited;
    for (int i = 0; i < SLOTS; i++) tmr_valid[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fill_table();
    test_due_walk();
    test_random_traffic(140);
    test_back_to_back(45);

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_replies.size()));
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d items: %0d sets (%0d on a full table), %0d kills (%0d bad ids)",
             items_sent, set_count, full_count, kill_count, invalid_count);
    $display("%0d process items fired %0d timers; %0d mismatches",
             proc_count, fire_count, error_count);
    if (error_count == 0) begin
      $display("** multi_slot_timer_table: PASSED **");
    end else begin
      $display("** multi_slot_timer_table: FAILED **");
    end
    $finish;
  end

endmodule
